@@ rtl/hdmt_pkg.sv @@
// hdmt_pkg: shared types, constants and span helpers for the depth max tree
// used by hdmt_front, hdmt_back and hierarchical_depth_max_tree_unit
// no dependencies
`timescale 1ns / 1ps

package hdmt_pkg;

    // coordinate width of a node span (canvas side is at most 511 pixels)
    localparam int CW      = 10;
    localparam int DEPTH_W = 24;
    localparam int COORD_W = 8;
    localparam int SIZE_W  = 9;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 24;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CANVAS_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CANVAS_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BACKGROUND    = 2'd2;

    localparam logic [SIZE_W-1:0]  SIZE_RESET = 9'd256;
    localparam logic [DEPTH_W-1:0] BG_RESET   = 24'hFFFFFF;

    typedef enum logic [1:0] {
        K_CLEAR   = 2'd0,
        K_WRITE   = 2'd1,
        K_REFRESH = 2'd2,
        K_QUERY   = 2'd3
    } t_kind;

    typedef struct packed {
        logic [CW-1:0] x0;
        logic [CW-1:0] x1;
        logic [CW-1:0] y0;
        logic [CW-1:0] y1;
    } t_span;

    typedef struct packed {
        t_kind              kind;
        t_span              rect;
        logic [DEPTH_W-1:0] depth;
    } t_cmd;

    typedef struct packed {
        logic [DEPTH_W-1:0] max_depth;
        logic               hit;
    } t_res;

    // child j of a span: bit 0 picks the right half, bit 1 the lower half
    function automatic t_span child_span(t_span s, logic [1:0] j);
        logic [CW:0]   xs;
        logic [CW:0]   ys;
        logic [CW-1:0] xm;
        logic [CW-1:0] ym;
        t_span         c;
        xs = {1'b0, s.x0} + {1'b0, s.x1};
        ys = {1'b0, s.y0} + {1'b0, s.y1};
        xm = xs[CW:1];
        ym = ys[CW:1];
        c.x0 = j[0] ? xm + 1'b1 : s.x0;
        c.x1 = j[0] ? s.x1 : xm;
        c.y0 = j[1] ? ym + 1'b1 : s.y0;
        c.y1 = j[1] ? s.y1 : ym;
        return c;
    endfunction

    function automatic logic is_leaf(t_span s);
        return (s.x0 == s.x1) && (s.y0 == s.y1);
    endfunction

    function automatic logic is_empty(t_span s);
        return (s.x0 > s.x1) || (s.y0 > s.y1);
    endfunction

    function automatic logic overlaps(t_span s, t_span r);
        return (r.x0 <= s.x1) && (s.x0 <= r.x1) && (r.y0 <= s.y1) && (s.y0 <= r.y1);
    endfunction

    function automatic logic covers(t_span s, t_span r);
        return (r.x0 <= s.x0) && (s.x1 <= r.x1) && (r.y0 <= s.y0) && (s.y1 <= r.y1);
    endfunction

endpackage

@@ rtl/hdmt_front.sv @@
// hdmt_front: accepts input items, decodes the mode and queues commands
// depends on hdmt_pkg
`timescale 1ns / 1ps

module hdmt_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [1:0]                    i_mode,
    input  logic [hdmt_pkg::COORD_W-1:0]  i_x_lo,
    input  logic [hdmt_pkg::COORD_W-1:0]  i_x_hi,
    input  logic [hdmt_pkg::COORD_W-1:0]  i_y_lo,
    input  logic [hdmt_pkg::COORD_W-1:0]  i_y_hi,
    input  logic [hdmt_pkg::DEPTH_W-1:0]  i_depth,
    output logic                          o_cmd_valid,
    input  logic                          i_cmd_ready,
    output hdmt_pkg::t_cmd                o_cmd
);
    import hdmt_pkg::*;

    t_cmd       r_buf [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    t_cmd       w_cmd;
    logic       w_push;
    logic       w_pop;

    // classify the item into a command with widened rectangle
    always_comb begin
        w_cmd.kind  = t_kind'(i_mode);
        w_cmd.rect.x0 = CW'(i_x_lo);
        w_cmd.rect.x1 = CW'(i_x_hi);
        w_cmd.rect.y0 = CW'(i_y_lo);
        w_cmd.rect.y1 = CW'(i_y_hi);
        w_cmd.depth = i_depth;
    end

    assign o_ready     = (r_cnt != 2'd2);
    assign w_push      = i_valid && o_ready;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign w_pop       = o_cmd_valid && i_cmd_ready;
    assign o_cmd       = r_buf[r_rp];

    // two entry command queue
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_buf[r_wp] <= w_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

`ifndef SYNTH
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3) else $error("queue count out of range");
    a_full_no_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd2 && !w_pop) |=> r_cnt == 2'd2) else $error("full queue changed");
    a_ptr_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd0) |-> (r_wp == r_rp)) else $error("empty queue pointers differ");
`endif

endmodule

@@ rtl/hdmt_back.sv @@
// hdmt_back: node memory and tree walker for clear, write, refresh and query
// depends on hdmt_pkg
`timescale 1ns / 1ps

module hdmt_back #(
    parameter int CANVAS_LOG2 = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cmd_valid,
    output logic                          o_cmd_ready,
    input  hdmt_pkg::t_cmd                i_cmd,
    input  logic [hdmt_pkg::SIZE_W-1:0]   i_canvas_width,
    input  logic [hdmt_pkg::SIZE_W-1:0]   i_canvas_height,
    input  logic [hdmt_pkg::DEPTH_W-1:0]  i_background,
    output logic                          o_res_valid,
    input  logic                          i_res_ready,
    output hdmt_pkg::t_res                o_res
);
    import hdmt_pkg::*;

    localparam longint NODE_COUNT = ((64'd1 << (2 * CANVAS_LOG2 + 2)) - 1) / 3;
    localparam int     IW = $clog2(NODE_COUNT);
    localparam int     LW = $clog2(CANVAS_LOG2 + 1);
    localparam int     MAX_SIDE = 1 << CANVAS_LOG2;

    typedef enum logic [3:0] {
        S_CLR, S_IDLE, S_WDESC, S_VISIT, S_CHILD,
        S_RRD, S_RWAIT, S_QRD, S_QWAIT, S_RET, S_DONE
    } t_state;

    typedef struct packed {
        logic [IW-1:0]      idx;
        t_span              span;
        logic [2:0]         j;
        logic [DEPTH_W-1:0] m;
    } t_frame;

    t_state             r_state;
    t_kind              r_kind;
    t_span              r_rect;
    t_span              r_s;
    logic [IW-1:0]      r_idx;
    logic [2:0]         r_j;
    logic [DEPTH_W-1:0] r_m;
    logic [DEPTH_W-1:0] r_depth;
    logic [DEPTH_W-1:0] r_best;
    logic               r_hit;
    logic [LW-1:0]      r_lvl;
    logic [IW-1:0]      r_cnt;
    logic [DEPTH_W-1:0] r_clr_val;
    logic               r_clr_item;
    logic [DEPTH_W-1:0] r_rdata;

    logic [DEPTH_W-1:0] mem [NODE_COUNT];
    t_frame             stack [CANVAS_LOG2 + 1];

    t_span              w_root;
    logic [SIZE_W+1:0]  w_wid;
    logic [SIZE_W+1:0]  w_hgt;
    logic [1:0]         w_wj;
    logic [1:0]         w_jsel;
    t_span              w_child;
    logic [IW+1:0]      w_cidx_full;
    logic [IW-1:0]      w_cidx;
    logic [CW:0]        w_xs;
    logic [CW:0]        w_ys;
    logic               w_we;
    logic [IW-1:0]      w_waddr;
    logic [DEPTH_W-1:0] w_wdata;
    logic [IW-1:0]      w_raddr;
    logic               w_push;
    t_frame             w_top;

    // effective canvas size, zero acts as one and large sizes are capped
    always_comb begin
        w_wid = {2'b00, i_canvas_width};
        w_hgt = {2'b00, i_canvas_height};
        if (w_wid == '0) w_wid = (SIZE_W+2)'(1);
        if (w_wid > (SIZE_W+2)'(MAX_SIDE)) w_wid = (SIZE_W+2)'(MAX_SIDE);
        if (w_hgt == '0) w_hgt = (SIZE_W+2)'(1);
        if (w_hgt > (SIZE_W+2)'(MAX_SIDE)) w_hgt = (SIZE_W+2)'(MAX_SIDE);
        w_root.x0 = '0;
        w_root.y0 = '0;
        w_root.x1 = CW'(w_wid - 1'b1);
        w_root.y1 = CW'(w_hgt - 1'b1);
    end

    // child selection: write descent steers by the pixel, walks by r_j
    always_comb begin
        w_xs = {1'b0, r_s.x0} + {1'b0, r_s.x1};
        w_ys = {1'b0, r_s.y0} + {1'b0, r_s.y1};
        w_wj[0] = (r_rect.x0 > w_xs[CW:1]);
        w_wj[1] = (r_rect.y0 > w_ys[CW:1]);
        w_jsel = (r_state == S_WDESC) ? w_wj : r_j[1:0];
        w_child = child_span(r_s, w_jsel);
        w_cidx_full = {r_idx, 2'b00} + (IW+2)'(w_jsel) + (IW+2)'(1);
        w_cidx = w_cidx_full[IW-1:0];
    end

    // memory port control
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_idx;
        w_wdata = r_m;
        case (r_state)
            S_CLR: begin
                w_we    = 1'b1;
                w_waddr = r_cnt;
                w_wdata = r_clr_val;
            end
            S_WDESC: begin
                w_we    = is_leaf(r_s);
                w_wdata = r_depth;
            end
            S_CHILD: begin
                w_we = (r_j == 3'd4) && (r_kind == K_REFRESH);
            end
            default: w_we = 1'b0;
        endcase
        w_raddr = (r_state == S_QRD) ? r_idx : w_cidx;
    end

    // node memory, registered read
    always_ff @(posedge i_clk) begin
        if (w_we) mem[w_waddr] <= w_wdata;
        r_rdata <= mem[w_raddr];
    end

    // walk stack of parent frames
    assign w_push = (r_state == S_CHILD) && (r_j != 3'd4) && !is_empty(w_child)
                    && overlaps(w_child, r_rect);
    assign w_top  = stack[r_lvl - 1'b1];

    always_ff @(posedge i_clk) begin
        if (w_push) stack[r_lvl] <= '{idx: r_idx, span: r_s, j: r_j, m: r_m};
    end

    assign o_cmd_ready = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_DONE);
    assign o_res.max_depth = r_best;
    assign o_res.hit       = r_hit;

    // walker state machine
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLR;
            r_cnt      <= '0;
            r_clr_val  <= BG_RESET;
            r_clr_item <= 1'b0;
            r_lvl      <= '0;
            r_best     <= '0;
            r_hit      <= 1'b0;
        end else begin
            unique case (r_state)
                S_CLR: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == IW'(NODE_COUNT - 1)) begin
                        r_state <= r_clr_item ? S_DONE : S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_cmd_valid) begin
                        r_kind  <= i_cmd.kind;
                        r_rect  <= i_cmd.rect;
                        r_depth <= i_cmd.depth;
                        r_best  <= '0;
                        r_hit   <= 1'b0;
                        r_lvl   <= '0;
                        r_idx   <= '0;
                        r_s     <= w_root;
                        unique case (i_cmd.kind)
                            K_CLEAR: begin
                                r_clr_val  <= i_background;
                                r_clr_item <= 1'b1;
                                r_cnt      <= '0;
                                r_state    <= S_CLR;
                            end
                            K_WRITE: begin
                                if (i_cmd.rect.x0 > w_root.x1 || i_cmd.rect.y0 > w_root.y1)
                                    r_state <= S_DONE;
                                else
                                    r_state <= S_WDESC;
                            end
                            default: r_state <= S_VISIT;
                        endcase
                    end
                end
                S_WDESC: begin
                    if (is_leaf(r_s)) begin
                        r_state <= S_DONE;
                    end else begin
                        r_s   <= w_child;
                        r_idx <= w_cidx;
                    end
                end
                S_VISIT: begin
                    r_j <= '0;
                    r_m <= '0;
                    if (r_kind == K_QUERY && covers(r_s, r_rect)) r_state <= S_QRD;
                    else if (is_leaf(r_s)) r_state <= S_RET;
                    else r_state <= S_CHILD;
                end
                S_CHILD: begin
                    if (r_j == 3'd4) begin
                        r_state <= S_RET;
                    end else if (is_empty(w_child)) begin
                        r_j <= r_j + 1'b1;
                    end else if (w_push) begin
                        r_lvl   <= r_lvl + 1'b1;
                        r_idx   <= w_cidx;
                        r_s     <= w_child;
                        r_state <= S_VISIT;
                    end else if (r_kind == K_REFRESH) begin
                        r_state <= S_RRD;
                    end else begin
                        r_j <= r_j + 1'b1;
                    end
                end
                S_RRD: r_state <= S_RWAIT;
                S_RWAIT: begin
                    if (r_rdata > r_m) r_m <= r_rdata;
                    r_j     <= r_j + 1'b1;
                    r_state <= S_CHILD;
                end
                S_QRD: r_state <= S_QWAIT;
                S_QWAIT: begin
                    if (!r_hit || r_rdata > r_best) r_best <= r_rdata;
                    r_hit   <= 1'b1;
                    r_state <= S_RET;
                end
                S_RET: begin
                    if (r_lvl == '0) begin
                        r_state <= S_DONE;
                    end else begin
                        r_lvl <= r_lvl - 1'b1;
                        r_idx <= w_top.idx;
                        r_s   <= w_top.span;
                        r_m   <= w_top.m;
                        if (r_kind == K_REFRESH) begin
                            r_j     <= w_top.j;
                            r_state <= S_RRD;
                        end else begin
                            r_j     <= w_top.j + 1'b1;
                            r_state <= S_CHILD;
                        end
                    end
                end
                S_DONE: begin
                    r_clr_item <= 1'b0;
                    if (i_res_ready) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTH
    a_lvl_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_lvl <= LW'(CANVAS_LOG2)) else $error("walk deeper than tree");
    a_read_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RRD) |=> (r_state == S_RWAIT)) else $error("read not consumed");
    a_hit_query: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.hit) |-> (r_kind == K_QUERY)) else $error("hit outside query");
    a_query_ro: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_CLR && r_state != S_IDLE && r_kind == K_QUERY) |-> !w_we)
        else $error("query wrote memory");
`endif

endmodule

@@ rtl/hierarchical_depth_max_tree_unit.sv @@
// hierarchical_depth_max_tree_unit: top level with configuration registers
// and result register; depends on hdmt_pkg, hdmt_front, hdmt_back
`timescale 1ns / 1ps

// Quadtree of maximum depths over a canvas of up to 2^CANVAS_LOG2 pixels a
// side, kept in a single-port-write node memory of (4^(CANVAS_LOG2+1)-1)/3
// entries. Every item gives one result. A clear sweeps the whole memory, one
// node a cycle; the same sweep runs after reset, and up to two items are
// taken into the queue meanwhile but none is carried out until it ends;
// configuration writes are taken at any time. A write descends one tree
// level a cycle down to its leaf and writes the leaf. Refresh and query walk
// the nodes that touch the rectangle, reading node values through the
// memory's registered read port. A refresh recomputes every inner node it
// reaches from its children, so a refresh of the whole canvas visits every
// node. Items queue two deep in front of the walker and a finished result
// waits in an output register.
module hierarchical_depth_max_tree_unit #(
    parameter int CANVAS_LOG2 = 8
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // x_lo[7:0], x_hi[15:8], y_lo[23:16], y_hi[31:24], depth[55:32]
    input  logic [55:0]                        s_axis_tdata,
    // mode[1:0]
    input  logic [1:0]                         s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // max_depth[23:0]
    output logic [23:0]                        m_axis_tdata,
    // hit[0]
    output logic [0:0]                         m_axis_tuser,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [hdmt_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [hdmt_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import hdmt_pkg::*;

    logic [SIZE_W-1:0]  r_canvas_width;
    logic [SIZE_W-1:0]  r_canvas_height;
    logic [DEPTH_W-1:0] r_background;
    logic               r_out_valid;
    t_res               r_out;
    logic               w_cmd_valid;
    logic               w_cmd_ready;
    t_cmd               w_cmd;
    logic               w_res_valid;
    logic               w_res_ready;
    t_res               w_res;

    // configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_canvas_width  <= SIZE_RESET;
            r_canvas_height <= SIZE_RESET;
            r_background    <= BG_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_CANVAS_WIDTH:  r_canvas_width  <= i_cfg_data[SIZE_W-1:0];
                REG_CANVAS_HEIGHT: r_canvas_height <= i_cfg_data[SIZE_W-1:0];
                REG_BACKGROUND:    r_background    <= i_cfg_data[DEPTH_W-1:0];
                default: ;
            endcase
        end
    end

    hdmt_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_mode      (s_axis_tuser),
        .i_x_lo      (s_axis_tdata[7:0]),
        .i_x_hi      (s_axis_tdata[15:8]),
        .i_y_lo      (s_axis_tdata[23:16]),
        .i_y_hi      (s_axis_tdata[31:24]),
        .i_depth     (s_axis_tdata[55:32]),
        .o_cmd_valid (w_cmd_valid),
        .i_cmd_ready (w_cmd_ready),
        .o_cmd       (w_cmd)
    );

    hdmt_back #(
        .CANVAS_LOG2 (CANVAS_LOG2)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd_valid     (w_cmd_valid),
        .o_cmd_ready     (w_cmd_ready),
        .i_cmd           (w_cmd),
        .i_canvas_width  (r_canvas_width),
        .i_canvas_height (r_canvas_height),
        .i_background    (r_background),
        .o_res_valid     (w_res_valid),
        .i_res_ready     (w_res_ready),
        .o_res           (w_res)
    );

    // output register
    assign w_res_ready = !r_out_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_ready) begin
            r_out_valid <= w_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_ready && w_res_valid) r_out <= w_res;
    end

    assign m_axis_tvalid   = r_out_valid;
    assign m_axis_tdata    = r_out.max_depth;
    assign m_axis_tuser[0] = r_out.hit;

endmodule
